>>> rtl/frame_rate_meter_top_assert.svh
// Assertion macros for the frame rate meter.
`ifndef FRAME_RATE_METER_TOP_ASSERT_SVH
`define FRAME_RATE_METER_TOP_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define FRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define FRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/frm_pkg.sv
`default_nettype none

package frm_pkg;

    localparam int FRAME_COUNT_BITS = 32;
    localparam int TIME_BITS        = 64;
    localparam int RATE_BITS        = 32;
    localparam int WINDOW_MS        = 1000;
    // 1000 = 1024 - 16 - 8
    localparam int WINDOW_SHIFT     = 10;
    // Dividend width: frame count times the window length
    localparam int DIV_BITS         = FRAME_COUNT_BITS + WINDOW_SHIFT;
    localparam int CNT_BITS         = $clog2(TIME_BITS);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // Clamp a quotient to the rate field width.
    function automatic logic [RATE_BITS-1:0] sat_rate(input logic [DIV_BITS-1:0] q);
        logic [DIV_BITS+RATE_BITS-1:0] qx;
        logic                          over;
        qx   = {{RATE_BITS{1'b0}}, q};
        over = |qx[DIV_BITS+RATE_BITS-1:RATE_BITS];
        return over ? {RATE_BITS{1'b1}} : qx[RATE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/frame_rate_meter_top.sv
`default_nettype none
// Frame rate meter. Each input transaction carries an operation in s_tuser (start, stop,
// frame tick) and a millisecond timestamp in s_tdata, and yields exactly one result
// transaction with a status bit (0 ok, 1 refused) and the latest measured frames per
// second. Start, stop, refused items and the first tick after a start pass from the
// idle state to the result state and then to the output register. Any other tick
// first forms the timestamp difference and the running sum bit-serially, one bit per
// cycle over the 64-bit time word. When the running sum reaches 1000 ms the rate is
// computed by a restoring divider that yields one quotient bit per cycle over the
// FRAME_COUNT_BITS + 10 bit dividend. One item is in work at a time; a finished result
// waits in the output register so a new item can be accepted while it is pending.
module frame_rate_meter_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [63:0] now_ms
    input  wire logic [63:0] s_tdata,
    // s_tuser: [1:0] operation
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: [0] status, [32:1] rate_per_second, [39:33] zero
    output logic [39:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);
    import frm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ACCUM  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    // Sequencer and architectural state
    state_t                      state_reg,    state_next;
    logic [CNT_BITS-1:0]         cnt_reg,      cnt_next;
    logic                        running_reg,  running_next;
    logic                        awaiting_reg, awaiting_next;
    logic [TIME_BITS-1:0]        prev_reg,     prev_next;
    logic [TIME_BITS-1:0]        elapsed_reg,  elapsed_next;
    logic [FRAME_COUNT_BITS-1:0] tally_reg,    tally_next;
    logic [RATE_BITS-1:0]        rate_reg,     rate_next;

    // Bit-serial adder / subtractor
    logic [TIME_BITS-1:0]        now_sr_reg,   now_sr_next;
    logic                        borrow_reg,   borrow_next;
    logic                        carry_reg,    carry_next;

    // Restoring divider
    logic [DIV_BITS-1:0]         dq_reg,       dq_next;
    logic [TIME_BITS-1:0]        rem_reg,      rem_next;

    // Result staging and output register
    logic                        status_reg,   status_next;
    logic                        m_valid_reg,  m_valid_next;
    logic                        m_status_reg, m_status_next;
    logic [RATE_BITS-1:0]        m_rate_reg,   m_rate_next;

    // Datapath terms
    logic                        a_bit, b_bit, e_bit, d_bit, s_bit;
    logic [TIME_BITS-1:0]        elapsed_shift;
    logic [TIME_BITS:0]          rem_sh, rem_diff;
    logic                        take;
    logic [DIV_BITS-1:0]         dq_shift;
    logic [DIV_BITS-1:0]         dividend;
    logic                        s_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_rate_reg, m_status_reg};

    // One bit of now - previous, then one bit of elapsed + difference, LSB first
    assign a_bit = now_sr_reg[0];
    assign b_bit = prev_reg[0];
    assign e_bit = elapsed_reg[0];
    assign d_bit = a_bit ^ b_bit ^ borrow_reg;
    assign s_bit = e_bit ^ d_bit ^ carry_reg;
    assign elapsed_shift = {s_bit, elapsed_reg[TIME_BITS-1:1]};

    // One quotient bit per cycle
    assign rem_sh   = {rem_reg, dq_reg[DIV_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, elapsed_reg};
    assign take     = !rem_diff[TIME_BITS];
    assign dq_shift = {dq_reg[DIV_BITS-2:0], take};

    // frames * 1000 as shifts and subtracts
    assign dividend = {tally_reg, {WINDOW_SHIFT{1'b0}}}
                    - DIV_BITS'({tally_reg, 4'b0})
                    - DIV_BITS'({tally_reg, 3'b0});

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        running_next  = running_reg;
        awaiting_next = awaiting_reg;
        prev_next     = prev_reg;
        elapsed_next  = elapsed_reg;
        tally_next    = tally_reg;
        rate_next     = rate_reg;
        now_sr_next   = now_sr_reg;
        borrow_next   = borrow_reg;
        carry_next    = carry_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_rate_next   = m_rate_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next  = ST_RESULT;
                    status_next = STATUS_REFUSED;
                    unique case (s_tuser)
                        OP_START: begin
                            if (!running_reg) begin
                                running_next  = 1'b1;
                                awaiting_next = 1'b1;
                                tally_next    = '0;
                                elapsed_next  = '0;
                                rate_next     = '0;
                                status_next   = STATUS_OK;
                            end
                        end
                        OP_STOP: begin
                            if (running_reg) begin
                                running_next = 1'b0;
                                status_next  = STATUS_OK;
                            end
                        end
                        OP_TICK: begin
                            if (running_reg) begin
                                status_next = STATUS_OK;
                                if (awaiting_reg) begin
                                    // first frame only records its time
                                    awaiting_next = 1'b0;
                                    prev_next     = s_tdata;
                                    tally_next    = '0;
                                    elapsed_next  = '0;
                                end else begin
                                    now_sr_next = s_tdata;
                                    borrow_next = 1'b0;
                                    carry_next  = 1'b0;
                                    cnt_next    = CNT_BITS'(TIME_BITS - 1);
                                    if (tally_reg != {FRAME_COUNT_BITS{1'b1}}) begin
                                        tally_next = tally_reg + 1'b1;
                                    end
                                    state_next = ST_ACCUM;
                                end
                            end
                        end
                        default: begin
                            status_next = STATUS_REFUSED;
                        end
                    endcase
                end
            end
            ST_ACCUM: begin
                // shift the new time into previous_time as it is consumed
                now_sr_next  = {1'b0, now_sr_reg[TIME_BITS-1:1]};
                prev_next    = {a_bit, prev_reg[TIME_BITS-1:1]};
                elapsed_next = elapsed_shift;
                borrow_next  = (!a_bit && b_bit) || (!a_bit && borrow_reg)
                            || (b_bit && borrow_reg);
                carry_next   = (e_bit && d_bit) || (e_bit && carry_reg)
                            || (d_bit && carry_reg);
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (elapsed_shift >= TIME_BITS'(WINDOW_MS)) begin
                        dq_next    = dividend;
                        rem_next   = '0;
                        cnt_next   = CNT_BITS'(DIV_BITS - 1);
                        state_next = ST_DIVIDE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_DIVIDE: begin
                rem_next = take ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
                dq_next  = dq_shift;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    rate_next    = sat_rate(dq_shift);
                    tally_next   = '0;
                    elapsed_next = '0;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_rate_next   = rate_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            running_reg  <= 1'b0;
            awaiting_reg <= 1'b1;
            prev_reg     <= '0;
            elapsed_reg  <= '0;
            tally_reg    <= '0;
            rate_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            running_reg  <= running_next;
            awaiting_reg <= awaiting_next;
            prev_reg     <= prev_next;
            elapsed_reg  <= elapsed_next;
            tally_reg    <= tally_next;
            rate_reg     <= rate_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        now_sr_reg   <= now_sr_next;
        borrow_reg   <= borrow_next;
        carry_reg    <= carry_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_rate_reg   <= m_rate_next;
    end

`include "frame_rate_meter_top_assert.svh"

    `FRM_ASSERT(a_accept_leaves_idle, s_fire |=> (state_reg != ST_IDLE), "accepted item left the sequencer idle")
    `FRM_ASSERT(a_rem_below_divisor, (state_reg == ST_DIVIDE) |-> (rem_reg < elapsed_reg), "divider remainder not below divisor")
    `FRM_ASSERT(a_divide_needs_window, (state_reg == ST_DIVIDE) |-> (elapsed_reg >= TIME_BITS'(WINDOW_MS)), "divide started below window length")
    `FRM_ASSERT(a_accum_while_running, (state_reg == ST_ACCUM) |-> (running_reg && !awaiting_reg), "accumulating while meter disarmed")
    `FRM_ASSERT(a_result_from_stage, $rose(m_valid_reg) |-> ($past(state_reg) == ST_RESULT), "result presented without a finished item")

endmodule

`default_nettype wire
